[rtl/bmdt_pkg.sv]
// ----------------------------------------------------------------------------
// Brushed motor drive tick: shared package
// Register indexes, reset values, gate codes and the structs passed between
// the front stage, the register file and the core.
// ----------------------------------------------------------------------------
package bmdt_pkg;

  // Timer period of the H-bridge PWM, 63..255.
  localparam int unsigned PERIOD_COUNT = 255;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 17;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_BATTERY_SCALE        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_UNDERVOLT_TRIP_MV    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_UNDERVOLT_RELEASE_MV = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OVERVOLT_TRIP_MV     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_OVERVOLT_RELEASE_MV  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_RELOAD       = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_EDGE_MARGIN          = 3'd6;

  // Reset values.
  localparam logic [15:0] RST_BATTERY_SCALE        = 16'd17815;
  localparam logic [16:0] RST_UNDERVOLT_TRIP_MV    = 17'd11200;
  localparam logic [16:0] RST_UNDERVOLT_RELEASE_MV = 17'd12320;
  localparam logic [16:0] RST_OVERVOLT_TRIP_MV     = 17'd17600;
  localparam logic [16:0] RST_OVERVOLT_RELEASE_MV  = 17'd15840;
  localparam logic [7:0]  RST_TIMEOUT_RELOAD       = 8'd100;
  localparam logic [5:0]  RST_EDGE_MARGIN          = 6'd8;

  // RC pulse window and center, in microseconds.
  localparam logic [15:0] RC_WIDTH_LOW    = 16'd750;
  localparam logic [15:0] RC_WIDTH_HIGH   = 16'd2250;
  localparam logic [16:0] RC_WIDTH_CENTER = 17'd1560;
  // floor(d * 256 / 300) = (d * RC_RECIP) >> RC_RECIP_SHIFT for d < 1024.
  localparam logic [19:0] RC_RECIP        = 20'd894785;
  localparam int unsigned RC_RECIP_SHIFT  = 20;

  localparam logic [16:0] MV_MAX = 17'd131071;

  // Gate patterns: bit0 lowA, bit1 lowB, bit2 highA, bit3 highB.
  localparam logic [3:0] GATES_FWD_DEAD = 4'd1;
  localparam logic [3:0] GATES_REV_DEAD = 4'd2;
  localparam logic [3:0] GATES_FWD_ON   = 4'd9;
  localparam logic [3:0] GATES_REV_ON   = 4'd6;
  localparam logic [3:0] GATES_LOW_BOTH = 4'd3;

  typedef struct packed {
    logic [15:0] battery_scale;
    logic [16:0] undervolt_trip_mv;
    logic [16:0] undervolt_release_mv;
    logic [16:0] overvolt_trip_mv;
    logic [16:0] overvolt_release_mv;
    logic [7:0]  timeout_reload;
    logic [5:0]  edge_margin;
  } cfg_t;

  // One tick after the front stage: converted voltage and link events.
  typedef struct packed {
    logic [16:0]        battery_mv;
    logic               rc_pulse_seen;
    logic               rc_in_window;
    logic signed [10:0] rc_ref;
    logic               bus_access_seen;
    logic signed [7:0]  bus_command;
  } tick_t;

endpackage

[rtl/bmdt_if.sv]
// ----------------------------------------------------------------------------
// Brushed motor drive tick: channel interfaces
// Valid/ready channels for the tick word and the result word.
// ----------------------------------------------------------------------------
interface bmdt_in_if;
  logic               valid;
  logic               ready;
  logic [9:0]         adc_sample;
  logic               rc_pulse_seen;
  logic [15:0]        rc_width;
  logic               bus_access_seen;
  logic signed [7:0]  bus_command;

  modport source (output valid, output adc_sample, output rc_pulse_seen, output rc_width,
                  output bus_access_seen, output bus_command, input ready);
  modport sink (input valid, input adc_sample, input rc_pulse_seen, input rc_width,
                input bus_access_seen, input bus_command, output ready);
endinterface

interface bmdt_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         status_flags;
  logic signed [8:0]  drive_level;
  logic [16:0]        battery_mv;
  logic [7:0]         reload_first_phase;
  logic [7:0]         reload_second_phase;
  logic [3:0]         gates_dead;
  logic [3:0]         gates_first_phase;
  logic [3:0]         gates_second_phase;

  modport source (output valid, output status_flags, output drive_level, output battery_mv,
                  output reload_first_phase, output reload_second_phase, output gates_dead,
                  output gates_first_phase, output gates_second_phase, input ready);
  modport sink (input valid, input status_flags, input drive_level, input battery_mv,
                input reload_first_phase, input reload_second_phase, input gates_dead,
                input gates_first_phase, input gates_second_phase, output ready);
endinterface

[rtl/bmdt_cfg.sv]
// ----------------------------------------------------------------------------
// Brushed motor drive tick: configuration registers
// Write-only register file; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module bmdt_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [bmdt_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [bmdt_pkg::CFG_DATA_W-1:0]  wr_data,
  output bmdt_pkg::cfg_t                   cfg
);
  import bmdt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.battery_scale        <= RST_BATTERY_SCALE;
      cfg.undervolt_trip_mv    <= RST_UNDERVOLT_TRIP_MV;
      cfg.undervolt_release_mv <= RST_UNDERVOLT_RELEASE_MV;
      cfg.overvolt_trip_mv     <= RST_OVERVOLT_TRIP_MV;
      cfg.overvolt_release_mv  <= RST_OVERVOLT_RELEASE_MV;
      cfg.timeout_reload       <= RST_TIMEOUT_RELOAD;
      cfg.edge_margin          <= RST_EDGE_MARGIN;
    end else if (wr_en) begin
      case (wr_index)
        REG_BATTERY_SCALE:        cfg.battery_scale        <= wr_data[15:0];
        REG_UNDERVOLT_TRIP_MV:    cfg.undervolt_trip_mv    <= wr_data;
        REG_UNDERVOLT_RELEASE_MV: cfg.undervolt_release_mv <= wr_data;
        REG_OVERVOLT_TRIP_MV:     cfg.overvolt_trip_mv     <= wr_data;
        REG_OVERVOLT_RELEASE_MV:  cfg.overvolt_release_mv  <= wr_data;
        REG_TIMEOUT_RELOAD:       cfg.timeout_reload       <= wr_data[7:0];
        REG_EDGE_MARGIN:          cfg.edge_margin          <= wr_data[5:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/bmdt_front.sv]
// ----------------------------------------------------------------------------
// Brushed motor drive tick: input stage
// Registers the tick word together with the battery conversion (word and
// battery scale) and the RC pulse scaling (word alone).
// ----------------------------------------------------------------------------
module bmdt_front (
  input  logic                clk,
  input  logic                rst,
  bmdt_in_if.sink             tick_in,
  input  logic [15:0]         battery_scale,
  input  logic                take,
  output logic                tick_valid,
  output bmdt_pkg::tick_t     tick
);
  import bmdt_pkg::*;

  logic [25:0]        mv_prod;
  logic [16:0]        mv_sat;
  logic signed [16:0] rc_diff;
  logic [16:0]        rc_abs;
  logic [29:0]        rc_prod;
  logic [9:0]         rc_quot;
  logic signed [10:0] rc_ref_calc;
  logic               rc_window;

  assign tick_in.ready = !tick_valid || take;

  always_comb begin
    mv_prod = 26'(tick_in.adc_sample) * 26'(battery_scale);
    mv_sat  = mv_prod[25] ? MV_MAX : mv_prod[24:8];

    rc_window = (tick_in.rc_width > RC_WIDTH_LOW) && (tick_in.rc_width < RC_WIDTH_HIGH);
    rc_diff   = $signed({1'b0, tick_in.rc_width}) - $signed(RC_WIDTH_CENTER);
    rc_abs    = rc_diff[16] ? 17'(-rc_diff) : 17'(rc_diff);
    // Inside the window the distance from center is below 1024.
    rc_prod   = 30'(rc_abs[9:0]) * 30'(RC_RECIP);
    rc_quot   = rc_prod[29:RC_RECIP_SHIFT];
    // Truncation toward zero: scale the magnitude, then restore the sign.
    rc_ref_calc = rc_diff[16] ? -$signed({1'b0, rc_quot}) : $signed({1'b0, rc_quot});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (tick_in.ready) begin
      tick_valid <= tick_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_in.ready && tick_in.valid) begin
      tick.battery_mv      <= mv_sat;
      tick.rc_pulse_seen   <= tick_in.rc_pulse_seen;
      tick.rc_in_window    <= rc_window;
      tick.rc_ref          <= rc_ref_calc;
      tick.bus_access_seen <= tick_in.bus_access_seen;
      tick.bus_command     <= tick_in.bus_command;
    end
  end

endmodule

[rtl/bmdt_core.sv]
// ----------------------------------------------------------------------------
// Brushed motor drive tick: control core
// Hysteresis flags, link freshness counters, reference selection, slew
// limiting and H-bridge pattern generation, into the result register.
// ----------------------------------------------------------------------------
module bmdt_core (
  input  logic            clk,
  input  logic            rst,
  input  bmdt_pkg::cfg_t  cfg,
  input  logic            tick_valid,
  input  bmdt_pkg::tick_t tick,
  output logic            take,
  bmdt_out_if.source      tick_out
);
  import bmdt_pkg::*;

  localparam logic [8:0] PERIOD_9 = 9'(PERIOD_COUNT);

  // State carried between ticks. The RC width is held already scaled.
  logic               undervolt_flag;
  logic               overvolt_flag;
  logic [7:0]         rc_fresh_count;
  logic [7:0]         bus_fresh_count;
  logic               held_rc_window;
  logic signed [10:0] held_rc_ref;
  logic signed [7:0]  held_bus_command;
  logic signed [8:0]  current_level;

  logic               undervolt_flag_next;
  logic               overvolt_flag_next;
  logic [7:0]         rc_count_loaded;
  logic [7:0]         bus_count_loaded;
  logic [7:0]         rc_fresh_count_next;
  logic [7:0]         bus_fresh_count_next;
  logic               rc_warn;
  logic               bus_warn;
  logic               rc_window_next;
  logic signed [10:0] rc_ref_next;
  logic signed [7:0]  bus_command_next;
  logic signed [10:0] ref_sel;
  logic signed [8:0]  ref_clamped;
  logic signed [8:0]  current_level_next;
  logic [8:0]         level_abs;
  logic [15:0]        mag_prod;
  logic [15:0]        mag_sum;
  logic [7:0]         mag;
  logic [3:0]         dead;
  logic [3:0]         g0;
  logic [3:0]         g1;

  assign take = tick_valid && (!tick_out.valid || tick_out.ready);

  always_comb begin
    // Voltage flags: the clearing test comes last and wins.
    undervolt_flag_next = undervolt_flag;
    if (tick.battery_mv < cfg.undervolt_trip_mv) undervolt_flag_next = 1'b1;
    if (tick.battery_mv > cfg.undervolt_release_mv) undervolt_flag_next = 1'b0;
    overvolt_flag_next = overvolt_flag;
    if (tick.battery_mv > cfg.overvolt_trip_mv) overvolt_flag_next = 1'b1;
    if (tick.battery_mv < cfg.overvolt_release_mv) overvolt_flag_next = 1'b0;

    rc_count_loaded  = tick.rc_pulse_seen ? cfg.timeout_reload : rc_fresh_count;
    bus_count_loaded = tick.bus_access_seen ? cfg.timeout_reload : bus_fresh_count;
    rc_warn  = (rc_count_loaded == 8'd0);
    bus_warn = (bus_count_loaded == 8'd0);
    rc_fresh_count_next  = rc_warn ? 8'd0 : rc_count_loaded - 8'd1;
    bus_fresh_count_next = bus_warn ? 8'd0 : bus_count_loaded - 8'd1;

    rc_window_next   = tick.rc_pulse_seen ? tick.rc_in_window : held_rc_window;
    rc_ref_next      = tick.rc_pulse_seen ? tick.rc_ref : held_rc_ref;
    bus_command_next = tick.bus_access_seen ? tick.bus_command : held_bus_command;

    ref_sel = '0;
    if (!bus_warn) ref_sel = {{2{bus_command_next[7]}}, bus_command_next, 1'b0};
    if (!rc_warn && rc_window_next) ref_sel = rc_ref_next;
    if (undervolt_flag_next || overvolt_flag_next) ref_sel = '0;

    if (ref_sel > 11'sd255) ref_clamped = 9'sd255;
    else if (ref_sel < -11'sd255) ref_clamped = -9'sd255;
    else ref_clamped = ref_sel[8:0];

    // One step per tick toward the reference.
    if (ref_clamped > current_level) current_level_next = current_level + 9'sd1;
    else if (ref_clamped < current_level) current_level_next = current_level - 9'sd1;
    else current_level_next = current_level;

    level_abs = current_level_next[8] ? 9'(-current_level_next) : 9'(current_level_next);
    mag_prod  = 16'(level_abs[7:0]) * 16'(PERIOD_COUNT);
    // Exact division by 255 for products below 65535.
    mag_sum   = mag_prod + (mag_prod >> 8) + 16'd1;
    mag       = mag_sum[15:8];

    if (current_level_next[8]) begin
      dead = GATES_REV_DEAD;
      g0   = GATES_REV_ON;
    end else begin
      dead = GATES_FWD_DEAD;
      g0   = GATES_FWD_ON;
    end
    g1 = GATES_LOW_BOTH;
    if ({1'b0, mag} > PERIOD_9 - {3'b000, cfg.edge_margin}) begin
      dead = g0;
      g1   = g0;
    end
    if ({1'b0, mag} < {3'b000, cfg.edge_margin}) begin
      dead = g1;
      g0   = g1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      undervolt_flag   <= 1'b0;
      overvolt_flag    <= 1'b0;
      rc_fresh_count   <= '0;
      bus_fresh_count  <= '0;
      held_rc_window   <= 1'b0;
      held_rc_ref      <= '0;
      held_bus_command <= '0;
      current_level    <= '0;
      tick_out.valid   <= 1'b0;
    end else begin
      if (take) begin
        undervolt_flag   <= undervolt_flag_next;
        overvolt_flag    <= overvolt_flag_next;
        rc_fresh_count   <= rc_fresh_count_next;
        bus_fresh_count  <= bus_fresh_count_next;
        held_rc_window   <= rc_window_next;
        held_rc_ref      <= rc_ref_next;
        held_bus_command <= bus_command_next;
        current_level    <= current_level_next;
        tick_out.valid   <= 1'b1;
      end else if (tick_out.ready) begin
        tick_out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tick_out.status_flags        <= {bus_warn, rc_warn, overvolt_flag_next,
                                       undervolt_flag_next};
      tick_out.drive_level         <= current_level_next;
      tick_out.battery_mv          <= tick.battery_mv;
      tick_out.reload_first_phase  <= ~mag;
      tick_out.reload_second_phase <= 8'(9'd255 - PERIOD_9 + {1'b0, mag});
      tick_out.gates_dead          <= dead;
      tick_out.gates_first_phase   <= g0;
      tick_out.gates_second_phase  <= g1;
    end
  end

endmodule

[rtl/brushed_motor_drive_tick_core.sv]
// ----------------------------------------------------------------------------
// Brushed motor drive tick: top level
// Battery supervision, link timeouts, speed reference and H-bridge drive
// patterns, one result word per control tick word.
// ----------------------------------------------------------------------------
//   Channel    Dir  Handshake          Carries
//   tick_in    in   valid / ready      adc, RC pulse event, bus event
//   tick_out   out  valid / ready      flags, drive level, mV, reloads, gates
//   wr_*       in   wr_en only         register index and data, no read-back
//
// An accepted word passes through the input register (converter multiply, RC
// scaling) and then through the control core into the result register.
// A new word is accepted every cycle unless the result word is stalled; the
// throughput is set by the core's single pass through flags, counters and
// slew, which feeds its own state. During a stall the input register still
// takes one more word. Synchronous reset clears the state and both valid
// bits; registers reload their default values.
module brushed_motor_drive_tick_core (
  input  logic                             clk,
  input  logic                             rst,
  bmdt_in_if.sink                          tick_in,
  bmdt_out_if.source                       tick_out,
  input  logic                             wr_en,
  input  logic [bmdt_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [bmdt_pkg::CFG_DATA_W-1:0]  wr_data
);
  import bmdt_pkg::*;

  cfg_t  cfg;
  tick_t tick;
  logic  tick_valid;
  logic  take;

  bmdt_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  bmdt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .tick_in       (tick_in),
    .battery_scale (cfg.battery_scale),
    .take          (take),
    .tick_valid    (tick_valid),
    .tick          (tick)
  );

  bmdt_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .tick_valid (tick_valid),
    .tick       (tick),
    .take       (take),
    .tick_out   (tick_out)
  );

endmodule

[rtl/bmdt_checker.sv]
// ----------------------------------------------------------------------------
// Brushed motor drive tick: port checker
// Watches the result channel for stall behavior, slew limit, level range,
// pattern consistency and an empty channel after reset.
// ----------------------------------------------------------------------------
module bmdt_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [8:0] drive_level,
  input logic [3:0]        gates_dead,
  input logic [3:0]        gates_first_phase,
  input logic [3:0]        gates_second_phase
);

  logic signed [8:0] last_level;
  logic signed [9:0] level_step;
  logic              out_fire;

  assign out_fire   = out_valid && out_ready;
  assign level_step = 10'(drive_level) - 10'(last_level);

  // The drive level starts at zero after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level <= '0;
    end else if (out_fire) begin
      last_level <= drive_level;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive_level) && $stable(gates_dead))
    else $error("result word changed while stalled");

  a_slew: assert property (@(posedge clk) disable iff (rst)
    out_fire |-> level_step == 10'sd0 || level_step == 10'sd1 || level_step == -10'sd1)
    else $error("drive level moved by more than one step");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> drive_level != -9'sd256)
    else $error("drive level out of range");

  a_gate_collapse: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> gates_dead == gates_first_phase || gates_second_phase == 4'd3)
    else $error("inconsistent gate patterns");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind brushed_motor_drive_tick_core bmdt_checker u_bmdt_checker (
  .clk                (clk),
  .rst                (rst),
  .out_valid          (tick_out.valid),
  .out_ready          (tick_out.ready),
  .drive_level        (tick_out.drive_level),
  .gates_dead         (tick_out.gates_dead),
  .gates_first_phase  (tick_out.gates_first_phase),
  .gates_second_phase (tick_out.gates_second_phase)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Brushed motor drive tick: testbench
// Drives control tick words through the valid/ready input channel and checks
// every result word against a cycle-free predictor of the battery flags, link
// timeouts, speed reference, slew and H-bridge patterns. Directed words cover
// the field extremes and corner cases; random drive sessions follow under
// several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  import bmdt_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [9:0]        adc;
    logic              rc_seen;
    logic [15:0]       rc_width;
    logic              bus_seen;
    logic signed [7:0] bus_cmd;
  } tick_word_t;

  typedef struct packed {
    logic [3:0]        flags;
    logic signed [8:0] level;
    logic [16:0]       mv;
    logic [7:0]        reload_a;
    logic [7:0]        reload_b;
    logic [3:0]        dead;
    logic [3:0]        first;
    logic [3:0]        second;
  } drive_result_t;

  logic                   clk;
  logic                   rst;
  logic                   wr_en;
  logic [CFG_INDEX_W-1:0] wr_index;
  logic [CFG_DATA_W-1:0]  wr_data;

  bmdt_in_if  tick_in ();
  bmdt_out_if tick_out ();

  brushed_motor_drive_tick_core dut (
    .clk      (clk),
    .rst      (rst),
    .tick_in  (tick_in),
    .tick_out (tick_out),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // Predictor copy of the registers.
  int scale_q8;
  int uv_set_mv;
  int uv_clear_mv;
  int ov_set_mv;
  int ov_clear_mv;
  int life_reload;
  int collapse_margin;

  // Predictor copy of the state.
  logic              uv_latched;
  logic              ov_latched;
  int                rc_life;
  int                bus_life;
  int                rc_width_held;
  logic signed [7:0] bus_cmd_held;
  int                level_now;

  drive_result_t expected_drive[$];
  drive_result_t due;
  int            fail_count;
  int            cycle_count;
  bit            tx_idle_on;
  bit            rx_stall_on;
  int            rx_hold_request;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void reset_drive_model();
    scale_q8        = int'(RST_BATTERY_SCALE);
    uv_set_mv       = int'(RST_UNDERVOLT_TRIP_MV);
    uv_clear_mv     = int'(RST_UNDERVOLT_RELEASE_MV);
    ov_set_mv       = int'(RST_OVERVOLT_TRIP_MV);
    ov_clear_mv     = int'(RST_OVERVOLT_RELEASE_MV);
    life_reload     = int'(RST_TIMEOUT_RELOAD);
    collapse_margin = int'(RST_EDGE_MARGIN);
    uv_latched      = 1'b0;
    ov_latched      = 1'b0;
    rc_life         = 0;
    bus_life        = 0;
    rc_width_held   = 0;
    bus_cmd_held    = '0;
    level_now       = 0;
  endfunction

  function automatic drive_result_t predict_drive(input tick_word_t w);
    longint        prod;
    int            mv;
    int            speed_ref;
    int            cmd;
    int            mag;
    logic          rc_warn;
    logic          bus_warn;
    logic [3:0]    dead;
    logic [3:0]    g_on;
    logic [3:0]    g_off;
    drive_result_t r;
    prod = longint'(w.adc) * longint'(scale_q8);
    mv = int'(prod >> 8);
    if (mv > int'(MV_MAX)) mv = int'(MV_MAX);
    // Clearing tests come last, so they win when both tests hold.
    if (mv < uv_set_mv) uv_latched = 1'b1;
    if (mv > uv_clear_mv) uv_latched = 1'b0;
    if (mv > ov_set_mv) ov_latched = 1'b1;
    if (mv < ov_clear_mv) ov_latched = 1'b0;

    if (w.rc_seen) begin
      rc_width_held = int'(w.rc_width);
      rc_life = life_reload;
    end
    if (w.bus_seen) begin
      bus_cmd_held = w.bus_cmd;
      bus_life = life_reload;
    end
    bus_warn = (bus_life == 0);
    if (!bus_warn) bus_life--;
    rc_warn = (rc_life == 0);
    if (!rc_warn) rc_life--;

    speed_ref = 0;
    if (!bus_warn) begin
      cmd = bus_cmd_held;
      speed_ref = cmd * 2;
    end
    if (!rc_warn && rc_width_held > int'(RC_WIDTH_LOW) && rc_width_held < int'(RC_WIDTH_HIGH))
      speed_ref = ((rc_width_held - int'(RC_WIDTH_CENTER)) * 256) / 300;
    if (uv_latched || ov_latched) speed_ref = 0;
    if (speed_ref > 255) speed_ref = 255;
    if (speed_ref < -255) speed_ref = -255;
    if (speed_ref > level_now + 1) speed_ref = level_now + 1;
    if (speed_ref < level_now - 1) speed_ref = level_now - 1;
    level_now = speed_ref;

    mag = ((level_now < 0) ? -level_now : level_now) * int'(PERIOD_COUNT) / 255;
    if (mag > int'(PERIOD_COUNT)) mag = int'(PERIOD_COUNT);
    // A zero level counts as forward.
    if (level_now < 0) begin
      dead = GATES_REV_DEAD;
      g_on = GATES_REV_ON;
    end else begin
      dead = GATES_FWD_DEAD;
      g_on = GATES_FWD_ON;
    end
    g_off = GATES_LOW_BOTH;
    if (mag > int'(PERIOD_COUNT) - collapse_margin) begin
      dead = g_on;
      g_off = g_on;
    end
    if (mag < collapse_margin) begin
      dead = g_off;
      g_on = g_off;
    end

    r.flags    = {bus_warn, rc_warn, ov_latched, uv_latched};
    r.level    = 9'(level_now);
    r.mv       = 17'(mv);
    r.reload_a = 8'(255 - mag);
    r.reload_b = 8'(255 - (int'(PERIOD_COUNT) - mag));
    r.dead     = dead;
    r.first    = g_on;
    r.second   = g_off;
    return r;
  endfunction

  function automatic logic [9:0] nominal_adc();
    longint target;
    longint a;
    int     jitter;
    if (scale_q8 == 0) return 10'($urandom_range(0, 1023));
    jitter = int'($urandom_range(0, 8)) - 4;
    target = (longint'(uv_clear_mv) + longint'(ov_clear_mv)) / 2;
    a = (target * 256) / scale_q8 + jitter;
    if (a < 0) a = 0;
    if (a > 1023) a = 1023;
    return 10'(a);
  endfunction

  function automatic void compare_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Result checker.
  always @(posedge clk) begin
    if (!rst && tick_out.valid && tick_out.ready) begin
      if (expected_drive.size() == 0) begin
        $error("result word with no expectation pending");
        fail_count++;
      end else begin
        due = expected_drive.pop_front();
        compare_field("status_flags", due.flags, tick_out.status_flags);
        compare_field("drive_level", due.level, tick_out.drive_level);
        compare_field("battery_mv", due.mv, tick_out.battery_mv);
        compare_field("reload_first_phase", due.reload_a, tick_out.reload_first_phase);
        compare_field("reload_second_phase", due.reload_b, tick_out.reload_second_phase);
        compare_field("gates_dead", due.dead, tick_out.gates_dead);
        compare_field("gates_first_phase", due.first, tick_out.gates_first_phase);
        compare_field("gates_second_phase", due.second, tick_out.gates_second_phase);
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request.
  initial begin
    int hold_left;
    hold_left = 0;
    tick_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_request > 0) begin
        hold_left = rx_hold_request;
        rx_hold_request = 0;
      end
      if (hold_left > 0) begin
        tick_out.ready = 1'b0;
        hold_left--;
      end else begin
        tick_out.ready = !rx_stall_on || ($urandom_range(99) >= 27);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_tick(input tick_word_t w);
    while (tx_idle_on && $urandom_range(99) < 27) begin
      tick_in.valid = 1'b0;
      @(negedge clk);
    end
    tick_in.valid           = 1'b1;
    tick_in.adc_sample      = w.adc;
    tick_in.rc_pulse_seen   = w.rc_seen;
    tick_in.rc_width        = w.rc_width;
    tick_in.bus_access_seen = w.bus_seen;
    tick_in.bus_command     = w.bus_cmd;
    @(posedge clk);
    while (!tick_in.ready) @(posedge clk);
    expected_drive.push_back(predict_drive(w));
    @(negedge clk);
    tick_in.valid = 1'b0;
  endtask

  task automatic send_tick_fields(input logic [9:0] adc, input logic rc_seen,
                                  input logic [15:0] rc_width, input logic bus_seen,
                                  input logic signed [7:0] bus_cmd);
    tick_word_t w;
    w.adc      = adc;
    w.rc_seen  = rc_seen;
    w.rc_width = rc_width;
    w.bus_seen = bus_seen;
    w.bus_cmd  = bus_cmd;
    send_tick(w);
  endtask

  // The sender stops until every pending result word is back.
  task automatic wait_drained();
    tick_in.valid = 1'b0;
    while (expected_drive.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = value;
    @(negedge clk);
    wr_en = 1'b0;
    case (idx)
      REG_BATTERY_SCALE:        scale_q8 = int'(value[15:0]);
      REG_UNDERVOLT_TRIP_MV:    uv_set_mv = int'(value);
      REG_UNDERVOLT_RELEASE_MV: uv_clear_mv = int'(value);
      REG_OVERVOLT_TRIP_MV:     ov_set_mv = int'(value);
      REG_OVERVOLT_RELEASE_MV:  ov_clear_mv = int'(value);
      REG_TIMEOUT_RELOAD:       life_reload = int'(value[7:0]);
      REG_EDGE_MARGIN:          collapse_margin = int'(value[5:0]);
      default: ;
    endcase
  endtask

  task automatic set_config(input int scale, input int uv_trip, input int uv_rel, input int ov_trip,
                            input int ov_rel, input int reload, input int margin);
    write_reg(REG_BATTERY_SCALE, 17'(scale));
    write_reg(REG_UNDERVOLT_TRIP_MV, 17'(uv_trip));
    write_reg(REG_UNDERVOLT_RELEASE_MV, 17'(uv_rel));
    write_reg(REG_OVERVOLT_TRIP_MV, 17'(ov_trip));
    write_reg(REG_OVERVOLT_RELEASE_MV, 17'(ov_rel));
    write_reg(REG_TIMEOUT_RELOAD, 17'(reload));
    write_reg(REG_EDGE_MARGIN, 17'(margin));
  endtask

  task automatic set_default_config();
    set_config(int'(RST_BATTERY_SCALE), int'(RST_UNDERVOLT_TRIP_MV),
               int'(RST_UNDERVOLT_RELEASE_MV), int'(RST_OVERVOLT_TRIP_MV),
               int'(RST_OVERVOLT_RELEASE_MV), int'(RST_TIMEOUT_RELOAD), int'(RST_EDGE_MARGIN));
  endtask

  // Sessions hold one RC width or bus command as the aim for a while, so the
  // slewed level can travel all the way to the rails; a tenth are pure noise.
  task automatic run_drive_sessions(input int count);
    int          left;
    int          run;
    int          mode;
    int          pick;
    logic [15:0] rc_aim;
    logic [7:0]  cmd_aim;
    tick_word_t  w;
    left = count;
    while (left > 0) begin
      run = $urandom_range(20, 250);
      if (run > left) run = left;
      mode = $urandom_range(99);
      pick = $urandom_range(99);
      if (pick < 10) rc_aim = RC_WIDTH_HIGH - 16'd1;
      else if (pick < 20) rc_aim = RC_WIDTH_LOW + 16'd1;
      else if (pick < 25) rc_aim = 16'(RC_WIDTH_CENTER);
      else rc_aim = 16'($urandom_range(751, 2249));
      pick = $urandom_range(99);
      if (pick < 10) cmd_aim = 8'h7f;
      else if (pick < 20) cmd_aim = 8'h80;
      else cmd_aim = 8'($urandom_range(0, 255));
      repeat (run) begin
        if (mode >= 90) begin
          w.adc      = 10'($urandom);
          w.rc_seen  = 1'($urandom);
          w.rc_width = 16'($urandom);
          w.bus_seen = 1'($urandom);
          w.bus_cmd  = 8'($urandom);
        end else begin
          w.adc      = ($urandom_range(99) < 4) ? 10'($urandom) : nominal_adc();
          w.rc_seen  = (mode < 40 || mode >= 75) ? ($urandom_range(99) < 40)
                                                 : ($urandom_range(99) < 3);
          w.rc_width = ($urandom_range(99) < 5) ? 16'($urandom)
                                                : 16'(int'(rc_aim) + int'($urandom_range(0, 4)) - 2);
          w.bus_seen = (mode >= 40) ? ($urandom_range(99) < 40) : ($urandom_range(99) < 5);
          w.bus_cmd  = ($urandom_range(99) < 5) ? 8'($urandom) : cmd_aim;
        end
        send_tick(w);
      end
      left -= run;
    end
  endtask

  task automatic test_directed_defaults();
    send_tick_fields(10'd0, 1'b0, 16'd0, 1'b0, 8'sd0);            // undervolt, both links stale
    send_tick_fields(10'd1023, 1'b0, 16'd0, 1'b0, 8'sd0);         // overvolt
    send_tick_fields(10'd202, 1'b0, 16'd0, 1'b0, 8'sd0);          // nominal, zero level
    send_tick_fields(10'd202, 1'b0, 16'd0, 1'b1, 8'sd127);
    send_tick_fields(10'd202, 1'b0, 16'd0, 1'b1, -8'sd128);
    send_tick_fields(10'd202, 1'b1, 16'd751, 1'b0, 8'sd0);
    send_tick_fields(10'd202, 1'b1, 16'd2249, 1'b0, 8'sd0);
    send_tick_fields(10'd202, 1'b1, 16'd750, 1'b0, 8'sd0);        // outside window, bus rules
    send_tick_fields(10'd202, 1'b1, 16'd2250, 1'b1, 8'sd100);
    send_tick_fields(10'd202, 1'b1, 16'd0, 1'b0, 8'sd0);
    send_tick_fields(10'd202, 1'b1, 16'hffff, 1'b0, 8'sd0);
    send_tick_fields(10'd202, 1'b1, 16'd1560, 1'b0, 8'sd0);
    send_tick_fields(10'd1023, 1'b1, 16'd2249, 1'b0, 8'sd0);      // error forces zero reference
    send_tick_fields(10'd202, 1'b0, 16'd0, 1'b1, 8'sd0);
    wait_drained();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_BATTERY_SCALE, 17'd65535);
    send_tick_fields(10'd1023, 1'b0, 16'd0, 1'b0, 8'sd0);         // product saturates
    send_tick_fields(10'd1, 1'b0, 16'd0, 1'b0, 8'sd0);
    wait_drained();
    // Trip above release: the releasing test is applied last and wins.
    write_reg(REG_UNDERVOLT_TRIP_MV, 17'd131071);
    write_reg(REG_UNDERVOLT_RELEASE_MV, 17'd0);
    write_reg(REG_OVERVOLT_TRIP_MV, 17'd0);
    write_reg(REG_OVERVOLT_RELEASE_MV, 17'd131071);
    send_tick_fields(10'd100, 1'b0, 16'd0, 1'b0, 8'sd0);
    send_tick_fields(10'd0, 1'b0, 16'd0, 1'b0, 8'sd0);
    send_tick_fields(10'd1023, 1'b0, 16'd0, 1'b0, 8'sd0);
    send_tick_fields(10'd300, 1'b0, 16'd0, 1'b0, 8'sd0);
    wait_drained();
    // A zero reload leaves both links stale even right after an event.
    set_config(65535, 0, 0, 131071, 131071, 0, 63);
    send_tick_fields(10'd256, 1'b1, 16'd2000, 1'b1, 8'sd50);
    wait_drained();
    write_reg(REG_TIMEOUT_RELOAD, 17'd255);
    send_tick_fields(10'd256, 1'b1, 16'd2249, 1'b0, 8'sd0);
    send_tick_fields(10'd256, 1'b0, 16'd0, 1'b1, -8'sd1);
    wait_drained();
  endtask

  task automatic test_random_configs();
    set_default_config();
    run_drive_sessions(450);
    wait_drained();

    set_config(int'(RST_BATTERY_SCALE), 11200, 12320, 17600, 15840, 3, 63);
    run_drive_sessions(300);
    wait_drained();

    set_config($urandom_range(8000, 30000), $urandom_range(5000, 11000),
               $urandom_range(11000, 14000), $urandom_range(17000, 25000),
               $urandom_range(14000, 17000), $urandom_range(1, 255), $urandom_range(0, 63));
    run_drive_sessions(300);
    wait_drained();

    // A long stretch with no idling on either side.
    tx_idle_on  = 1'b0;
    rx_stall_on = 1'b0;
    set_config(65535, 0, 0, 131071, 131071, 255, 0);
    run_drive_sessions(300);
    wait_drained();
    tx_idle_on  = 1'b1;
    rx_stall_on = 1'b1;

    set_config(30000, 12000, 13000, 20000, 19000, 1, 32);
    run_drive_sessions(250);
    wait_drained();

    // A zero scale reads every battery as empty.
    set_config(0, 1, 5, 131071, 131071, 50, 8);
    run_drive_sessions(100);
    wait_drained();
  endtask

  // The receiver stops long enough that the block fills and stalls its input.
  task automatic test_backpressure();
    set_default_config();
    rx_hold_request = 200;
    run_drive_sessions(30);
    wait_drained();
  endtask

  initial begin
    rst                     = 1'b1;
    wr_en                   = 1'b0;
    wr_index                = '0;
    wr_data                 = '0;
    tick_in.valid           = 1'b0;
    tick_in.adc_sample      = '0;
    tick_in.rc_pulse_seen   = 1'b0;
    tick_in.rc_width        = '0;
    tick_in.bus_access_seen = 1'b0;
    tick_in.bus_command     = '0;
    fail_count              = 0;
    tx_idle_on              = 1'b1;
    rx_stall_on             = 1'b1;
    rx_hold_request         = 0;
    reset_drive_model();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_defaults();
    test_register_extremes();
    test_random_configs();
    test_backpressure();

    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_drive.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
